@@ sv/crsc_pkg.sv @@
// ----------------------------------------------------------------------------
// crsc_pkg: shared types and constants of the charlieplex ring scan controller
// Item and register codes, line drive type, buzzer pattern tables.
// ----------------------------------------------------------------------------
package crsc_pkg;

  localparam int unsigned LINES      = 4;
  localparam int unsigned SLOT_W     = 2;
  localparam int unsigned MAP_W      = 24;
  localparam int unsigned FRAME_W    = 12;
  localparam int unsigned HOLD_W     = 6;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned STEP_W     = 9;
  localparam int unsigned PAT_W      = 3;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [HOLD_W-1:0] SAMPLE_STEP_MS   = 6'd2;
  localparam logic [HOLD_W-1:0] RELEASE_RESET_MS = 6'd30;

  // Item codes
  typedef enum logic [1:0] {
    ACT_TICK          = 2'd0,
    ACT_SET_FRAME     = 2'd1,
    ACT_START_PATTERN = 2'd2,
    ACT_TAKE_EVENTS   = 2'd3
  } action_e;

  // Register indexes (word address bits 3:2)
  typedef enum logic [1:0] {
    REG_ANODE_MAP    = 2'd0,
    REG_CATHODE_MAP  = 2'd1,
    REG_RELEASE_TIME = 2'd2
  } cfg_reg_e;

  // Buzzer patterns
  localparam logic [PAT_W-1:0] PAT_CHIRP     = 3'd0;
  localparam logic [PAT_W-1:0] PAT_START     = 3'd1;
  localparam logic [PAT_W-1:0] PAT_WIN       = 3'd2;
  localparam logic [PAT_W-1:0] PAT_NEAR      = 3'd3;
  localparam logic [PAT_W-1:0] PAT_MISS      = 3'd4;
  localparam logic [PAT_W-1:0] PATTERN_COUNT = 3'd5;

  localparam logic [PAT_W-1:0] WIN_STEPS = 3'd5;

  typedef struct packed {
    logic [LINES-1:0] enable;
    logic [LINES-1:0] level;
  } drive_t;

  // Number of steps in a pattern; zero for unknown codes
  function automatic logic [PAT_W-1:0] tone_len(input logic [PAT_W-1:0] sel);
    logic [PAT_W-1:0] len;
    case (sel)
      PAT_CHIRP, PAT_START, PAT_NEAR, PAT_MISS: len = 3'd1;
      PAT_WIN:                                  len = WIN_STEPS;
      default:                                  len = 3'd0;
    endcase
    return len;
  endfunction

  // Duration in ms of one step of a pattern
  function automatic logic [STEP_W-1:0] step_length(input logic [PAT_W-1:0] sel,
                                                    input logic [PAT_W-1:0] idx);
    logic [STEP_W-1:0] len;
    case (sel)
      PAT_CHIRP: len = 9'd40;
      PAT_START: len = 9'd60;
      PAT_WIN: begin
        if (idx >= WIN_STEPS) len = 9'd0;
        else if (idx[0])      len = 9'd50;
        else                  len = 9'd30;
      end
      PAT_NEAR:  len = 9'd150;
      PAT_MISS:  len = 9'd450;
      default:   len = 9'd0;
    endcase
    return len;
  endfunction

endpackage

@@ sv/crsc_debounce.sv @@
// ----------------------------------------------------------------------------
// crsc_debounce: leading-edge debounce of one button
// Latch an event on the first pressed sample; re-arm after the release time.
// ----------------------------------------------------------------------------
module crsc_debounce (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        sample_en_i,
  input  logic                        pressed_i,
  input  logic [crsc_pkg::HOLD_W-1:0] release_time_i,
  input  logic                        take_en_i,
  output logic                        taken_o
);

  logic                        armed_q, armed_d;
  logic                        event_q, event_d;
  logic [crsc_pkg::HOLD_W-1:0] hold_q, hold_d;

  always_comb begin
    armed_d = armed_q;
    event_d = event_q;
    hold_d  = hold_q;
    if (take_en_i) begin
      event_d = 1'b0;
    end else if (sample_en_i) begin
      if (pressed_i) begin
        if (armed_q) begin
          armed_d = 1'b0;
          event_d = 1'b1;
        end
        hold_d = release_time_i;
      end else if (!armed_q) begin
        if (hold_q > crsc_pkg::SAMPLE_STEP_MS) begin
          hold_d = hold_q - crsc_pkg::SAMPLE_STEP_MS;
        end else begin
          hold_d  = '0;
          armed_d = 1'b1;
        end
      end
    end
  end

  assign taken_o = take_en_i & event_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b1;
      event_q <= 1'b0;
      hold_q  <= '0;
    end else begin
      armed_q <= armed_d;
      event_q <= event_d;
      hold_q  <= hold_d;
    end
  end

endmodule

@@ sv/crsc_row_drive.sv @@
// ----------------------------------------------------------------------------
// crsc_row_drive: line drive for one scan row
// Collect cathodes of lit LEDs whose anode is the row; blank an empty row.
// ----------------------------------------------------------------------------
module crsc_row_drive #(
  parameter int unsigned RING_POSITIONS = 12
) (
  input  logic [RING_POSITIONS-1:0]      lit_frame_i,
  input  logic [crsc_pkg::MAP_W-1:0]     anode_map_i,
  input  logic [crsc_pkg::MAP_W-1:0]     cathode_map_i,
  input  logic [crsc_pkg::SLOT_W-1:0]    row_i,
  output crsc_pkg::drive_t               drive_o
);

  logic [crsc_pkg::LINES-1:0] lows;
  logic [crsc_pkg::LINES-1:0] row_onehot;

  always_comb begin
    lows = '0;
    for (int i = 0; i < RING_POSITIONS; i++) begin
      if (lit_frame_i[i] && (anode_map_i[2*i +: 2] == row_i)) begin
        lows[cathode_map_i[2*i +: 2]] = 1'b1;
      end
    end
  end

  assign row_onehot = crsc_pkg::LINES'(1) << row_i;

  always_comb begin
    if (lows != '0) begin
      drive_o.level  = row_onehot;
      drive_o.enable = lows | row_onehot;
    end else begin
      drive_o.level  = '0;
      drive_o.enable = '0;
    end
  end

endmodule

@@ sv/crsc_buzzer.sv @@
// ----------------------------------------------------------------------------
// crsc_buzzer: buzzer gate sequencer
// Step through on/off durations of the selected pattern, one ms per tick.
// ----------------------------------------------------------------------------
module crsc_buzzer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       tick_en_i,
  input  logic                       start_en_i,
  input  logic [crsc_pkg::PAT_W-1:0] pattern_id_i,
  output logic                       gate_o
);

  logic [crsc_pkg::PAT_W-1:0]  sel_q, sel_d;
  logic                        active_q, active_d;
  logic [crsc_pkg::PAT_W-1:0]  idx_q, idx_d;
  logic [crsc_pkg::STEP_W-1:0] left_q, left_d;
  logic                        gate_q, gate_d;
  logic [crsc_pkg::STEP_W-1:0] left_dec;
  logic [crsc_pkg::PAT_W-1:0]  idx_inc;

  assign left_dec = left_q - 1'b1;
  assign idx_inc  = idx_q + 1'b1;

  always_comb begin
    sel_d    = sel_q;
    active_d = active_q;
    idx_d    = idx_q;
    left_d   = left_q;
    gate_d   = gate_q;
    if (start_en_i) begin
      // drop unknown patterns
      if (pattern_id_i < crsc_pkg::PATTERN_COUNT) begin
        sel_d    = pattern_id_i;
        idx_d    = '0;
        left_d   = crsc_pkg::step_length(pattern_id_i, '0);
        active_d = 1'b1;
        gate_d   = 1'b1;
      end
    end else if (tick_en_i && active_q) begin
      left_d = left_dec;
      if (left_dec == '0) begin
        idx_d = idx_inc;
        if (idx_inc >= crsc_pkg::tone_len(sel_q)) begin
          active_d = 1'b0;
          gate_d   = 1'b0;
        end else begin
          left_d = crsc_pkg::step_length(sel_q, idx_inc);
          gate_d = ~idx_inc[0];
        end
      end
    end
  end

  assign gate_o = gate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q    <= '0;
      active_q <= 1'b0;
      idx_q    <= '0;
      left_q   <= '0;
      gate_q   <= 1'b0;
    end else begin
      sel_q    <= sel_d;
      active_q <= active_d;
      idx_q    <= idx_d;
      left_q   <= left_d;
      gate_q   <= gate_d;
    end
  end

endmodule

@@ sv/charlieplex_ring_scan_controller.sv @@
// ----------------------------------------------------------------------------
// charlieplex_ring_scan_controller: ring LED scan, key debounce, buzzer gate
// Top level with input register, item decode, state and result registers.
// ----------------------------------------------------------------------------
// Every accepted beat yields exactly one result beat. A beat is first held in
// an input register; once the result slot is free or being taken, its action
// runs through one short pass of logic (debounce step, row drive, counters,
// buzzer step) and updates the block state, which doubles as the result
// register. One beat per cycle is taken as long as results are taken, set by
// the single update pass. While a result is stalled one more beat waits in the
// input register, then input stalls too. Line drive (line_enable_o,
// line_level_o) only changes on tick beats; catch_event_o and start_event_o
// are 1 only for take-events beats that find a latched event. Registers: anode
// map at 0x0, cathode map at 0x4, release time at 0x8; write them only while no
// beat is in flight.
// ----------------------------------------------------------------------------
module charlieplex_ring_scan_controller #(
  parameter int unsigned RING_POSITIONS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // item channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          action_i,
  input  logic                                catch_pressed_i,
  input  logic                                start_pressed_i,
  input  logic [crsc_pkg::FRAME_W-1:0]        frame_bits_i,
  input  logic [crsc_pkg::PAT_W-1:0]          pattern_id_i,
  input  logic [1:0]                          take_mask_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [crsc_pkg::LINES-1:0]          line_enable_o,
  output logic [crsc_pkg::LINES-1:0]          line_level_o,
  output logic                                buzzer_gate_o,
  output logic                                catch_event_o,
  output logic                                start_event_o,
  output logic [crsc_pkg::TICK_W-1:0]         tick_count_o,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [crsc_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [crsc_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [crsc_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  // ---------------------------------------------------------------- registers
  logic [crsc_pkg::MAP_W-1:0]  anode_map_q;
  logic [crsc_pkg::MAP_W-1:0]  cathode_map_q;
  logic [crsc_pkg::HOLD_W-1:0] release_time_q;
  logic                        cfg_write;
  crsc_pkg::cfg_reg_e          cfg_sel;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign cfg_sel   = crsc_pkg::cfg_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anode_map_q    <= '0;
      cathode_map_q  <= '0;
      release_time_q <= crsc_pkg::RELEASE_RESET_MS;
    end else if (cfg_write) begin
      case (cfg_sel)
        crsc_pkg::REG_ANODE_MAP:    anode_map_q    <= pwdata[crsc_pkg::MAP_W-1:0];
        crsc_pkg::REG_CATHODE_MAP:  cathode_map_q  <= pwdata[crsc_pkg::MAP_W-1:0];
        crsc_pkg::REG_RELEASE_TIME: release_time_q <= pwdata[crsc_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      crsc_pkg::REG_ANODE_MAP:    prdata = crsc_pkg::CFG_DATA_W'(anode_map_q);
      crsc_pkg::REG_CATHODE_MAP:  prdata = crsc_pkg::CFG_DATA_W'(cathode_map_q);
      crsc_pkg::REG_RELEASE_TIME: prdata = crsc_pkg::CFG_DATA_W'(release_time_q);
      default:                    prdata = '0;
    endcase
  end

  // ----------------------------------------------------------- input register
  logic                         in_vld_q, in_vld_d;
  crsc_pkg::action_e            act_q;
  logic                         catch_q;
  logic                         start_q;
  logic [crsc_pkg::FRAME_W-1:0] frame_q;
  logic [crsc_pkg::PAT_W-1:0]   pid_q;
  logic [1:0]                   take_q;
  logic                         in_accept;
  logic                         advance;

  // Run the held beat whenever the result slot is free or being taken.
  assign advance    = in_vld_q & (~out_valid_o | ~out_stall_i);
  assign in_stall_o = in_vld_q & ~advance;
  assign in_accept  = in_valid_i & ~in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_accept)    in_vld_d = 1'b1;
    else if (advance) in_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      act_q   <= crsc_pkg::action_e'(action_i);
      catch_q <= catch_pressed_i;
      start_q <= start_pressed_i;
      frame_q <= frame_bits_i;
      pid_q   <= pattern_id_i;
      take_q  <= take_mask_i;
    end
  end

  // ------------------------------------------------------------ item decode
  logic do_tick, do_frame, do_start, do_take;

  always_comb begin
    do_tick  = 1'b0;
    do_frame = 1'b0;
    do_start = 1'b0;
    do_take  = 1'b0;
    if (advance) begin
      case (act_q)
        crsc_pkg::ACT_TICK:          do_tick  = 1'b1;
        crsc_pkg::ACT_SET_FRAME:     do_frame = 1'b1;
        crsc_pkg::ACT_START_PATTERN: do_start = 1'b1;
        crsc_pkg::ACT_TAKE_EVENTS:   do_take  = 1'b1;
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------- state
  logic [RING_POSITIONS-1:0]    lit_frame_q;
  logic [crsc_pkg::SLOT_W-1:0]  slot_q, slot_next;
  logic [crsc_pkg::TICK_W-1:0]  ms_q;
  crsc_pkg::drive_t             drive_q, row_drive;
  logic                         out_vld_q, out_vld_d;
  logic                         took_catch_q, took_start_q;
  logic                         took_catch, took_start;

  assign slot_next = slot_q + 1'b1;

  // Odd slots sample the catch button, even slots the start button.
  crsc_debounce u_catch_btn (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_en_i    (do_tick & slot_q[0]),
    .pressed_i      (catch_q),
    .release_time_i (release_time_q),
    .take_en_i      (do_take & take_q[0]),
    .taken_o        (took_catch)
  );

  crsc_debounce u_start_btn (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_en_i    (do_tick & ~slot_q[0]),
    .pressed_i      (start_q),
    .release_time_i (release_time_q),
    .take_en_i      (do_take & take_q[1]),
    .taken_o        (took_start)
  );

  // Drive the row the scan moves to on this tick.
  crsc_row_drive #(
    .RING_POSITIONS (RING_POSITIONS)
  ) u_row_drive (
    .lit_frame_i   (lit_frame_q),
    .anode_map_i   (anode_map_q),
    .cathode_map_i (cathode_map_q),
    .row_i         (slot_next),
    .drive_o       (row_drive)
  );

  crsc_buzzer u_buzzer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_en_i    (do_tick),
    .start_en_i   (do_start),
    .pattern_id_i (pid_q),
    .gate_o       (buzzer_gate_o)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance)          out_vld_d = 1'b1;
    else if (!out_stall_i) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lit_frame_q  <= '0;
      slot_q       <= '0;
      ms_q         <= '0;
      drive_q      <= '0;
      out_vld_q    <= 1'b0;
      took_catch_q <= 1'b0;
      took_start_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (advance) begin
        took_catch_q <= took_catch;
        took_start_q <= took_start;
      end
      if (do_frame) begin
        lit_frame_q <= frame_q[RING_POSITIONS-1:0];
      end
      if (do_tick) begin
        slot_q  <= slot_next;
        ms_q    <= ms_q + 1'b1;
        drive_q <= row_drive;
      end
    end
  end

  // State registers change only when a result is loaded, so they are the result.
  assign out_valid_o   = out_vld_q;
  assign line_enable_o = drive_q.enable;
  assign line_level_o  = drive_q.level;
  assign catch_event_o = took_catch_q;
  assign start_event_o = took_start_q;
  assign tick_count_o  = ms_q;

endmodule

@@ sv/crsc_checker.sv @@
// ----------------------------------------------------------------------------
// crsc_checker: port-level checks of the ring scan controller
// Result hold under stall, line drive shape, no result without an item beat.
// ----------------------------------------------------------------------------
module crsc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [crsc_pkg::LINES-1:0]  line_enable_o,
  input logic [crsc_pkg::LINES-1:0]  line_level_o,
  input logic                        buzzer_gate_o,
  input logic                        catch_event_o,
  input logic                        start_event_o,
  input logic [crsc_pkg::TICK_W-1:0] tick_count_o
);

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(line_enable_o) &&
      $stable(line_level_o) && $stable(buzzer_gate_o) && $stable(catch_event_o) &&
      $stable(start_event_o) && $stable(tick_count_o))
    else $error("result changed while stalled");

  // At most one line is driven high, and only an enabled one.
  a_one_anode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0(line_level_o) && ((line_level_o & ~line_enable_o) == '0))
    else $error("bad anode drive");

  // A row is either blanked or drives its anode line high.
  a_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((line_enable_o == '0) == (line_level_o == '0)))
    else $error("row drive neither blanked nor complete");

  // A new result beat only follows an item beat accepted into the input register.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without item");

endmodule

bind charlieplex_ring_scan_controller crsc_checker u_crsc_checker (.*);

@@ tb/tb_charlieplex_ring_scan_controller.sv @@
// ----------------------------------------------------------------------------
// tb_charlieplex_ring_scan_controller: self-checking bench for the ring scan
// Drives item beats and register writes into the block. A scoreboard class
// predicts every result beat from its own copy of the scan, debounce and
// buzzer state and checks the results in order. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_charlieplex_ring_scan_controller;
  import crsc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 60;

  typedef struct packed {
    logic [LINES-1:0]  line_enable;
    logic [LINES-1:0]  line_level;
    logic              buzzer_gate;
    logic              catch_event;
    logic              start_event;
    logic [TICK_W-1:0] tick_count;
  } scan_result_t;

  // Scoreboard: mirrors the block state and owes one result per item beat
  class ring_scoreboard;
    bit [MAP_W-1:0]   anode_map;
    bit [MAP_W-1:0]   cathode_map;
    bit [HOLD_W-1:0]  release_ms;
    bit [FRAME_W-1:0] lit_frame;
    bit [SLOT_W-1:0]  scan_slot;
    bit [1:0]         armed;
    bit [1:0]         latched;
    bit [HOLD_W-1:0]  hold_left [2];
    bit [TICK_W-1:0]  ms_count;
    bit [PAT_W-1:0]   tone_sel;
    bit [PAT_W-1:0]   tone_idx;
    bit               tone_on;
    bit [STEP_W-1:0]  tone_left;
    bit               gate_on;
    bit [LINES-1:0]   drive_en;
    bit [LINES-1:0]   drive_lvl;
    scan_result_t     queued_scans[$];
    int unsigned      mismatches;

    function new();
      armed      = 2'b11;
      release_ms = RELEASE_RESET_MS;
      mismatches = 0;
    endfunction

    function int unsigned tone_steps(bit [PAT_W-1:0] sel);
      return (sel == PAT_WIN) ? 5 : 1;
    endfunction

    function bit [STEP_W-1:0] tone_ms(bit [PAT_W-1:0] sel, bit [PAT_W-1:0] idx);
      case (sel)
        PAT_CHIRP: return 9'd40;
        PAT_START: return 9'd60;
        PAT_WIN:   return idx[0] ? 9'd50 : 9'd30;
        PAT_NEAR:  return 9'd150;
        default:   return 9'd450;
      endcase
    endfunction

    function void set_reg(cfg_reg_e idx, bit [CFG_DATA_W-1:0] value);
      case (idx)
        REG_ANODE_MAP:    anode_map   = value[MAP_W-1:0];
        REG_CATHODE_MAP:  cathode_map = value[MAP_W-1:0];
        REG_RELEASE_TIME: release_ms  = value[HOLD_W-1:0];
        default: ;
      endcase
    endfunction

    // Leading-edge debounce of one button, b = 0 catch, b = 1 start
    function void debounce(int b, bit pressed);
      if (pressed) begin
        if (armed[b]) begin
          armed[b]   = 1'b0;
          latched[b] = 1'b1;
        end
        hold_left[b] = release_ms;
      end else if (!armed[b]) begin
        if (hold_left[b] > SAMPLE_STEP_MS) begin
          hold_left[b] = hold_left[b] - SAMPLE_STEP_MS;
        end else begin
          hold_left[b] = '0;
          armed[b]     = 1'b1;
        end
      end
    endfunction

    function void buzzer_step();
      if (!tone_on) return;
      tone_left = tone_left - 1'b1;
      if (tone_left != 0) return;
      tone_idx = tone_idx + 1'b1;
      if (tone_idx >= tone_steps(tone_sel)) begin
        tone_on = 1'b0;
        gate_on = 1'b0;
        return;
      end
      tone_left = tone_ms(tone_sel, tone_idx);
      gate_on   = ~tone_idx[0];
    endfunction

    // Advance the mirrored state by one accepted item beat, owe its result
    function void note_beat(action_e act, bit catch_b, bit start_b,
                            bit [FRAME_W-1:0] frame, bit [PAT_W-1:0] pat, bit [1:0] mask);
      scan_result_t r;
      bit [LINES-1:0] lows;
      bit [1:0] an;
      bit [1:0] ca;
      r = '0;
      case (act)
        ACT_TICK: begin
          if (scan_slot[0]) debounce(0, catch_b);
          else              debounce(1, start_b);
          scan_slot = scan_slot + 1'b1;
          lows = '0;
          for (int i = 0; i < FRAME_W; i++) begin
            an = anode_map[2*i +: 2];
            ca = cathode_map[2*i +: 2];
            if (lit_frame[i] && an == scan_slot) lows[ca] = 1'b1;
          end
          if (lows != 0) begin
            drive_lvl = 4'b0001 << scan_slot;
            drive_en  = lows | drive_lvl;
          end else begin
            drive_lvl = '0;
            drive_en  = '0;
          end
          ms_count = ms_count + 1'b1;
          buzzer_step();
        end
        ACT_SET_FRAME: lit_frame = frame;
        ACT_START_PATTERN: begin
          if (pat < PATTERN_COUNT) begin
            tone_sel  = pat;
            tone_idx  = '0;
            tone_left = tone_ms(pat, '0);
            tone_on   = 1'b1;
            gate_on   = 1'b1;
          end
        end
        default: begin
          if (mask[0]) begin
            r.catch_event = latched[0];
            latched[0]    = 1'b0;
          end
          if (mask[1]) begin
            r.start_event = latched[1];
            latched[1]    = 1'b0;
          end
        end
      endcase
      r.line_enable = drive_en;
      r.line_level  = drive_lvl;
      r.buzzer_gate = gate_on;
      r.tick_count  = ms_count;
      queued_scans.push_back(r);
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_scan(scan_result_t got);
      scan_result_t want;
      if (queued_scans.size() == 0) begin
        $display("%0t: result beat with nothing owed, expected none actual %p", $time, got);
        mismatches++;
        return;
      end
      want = queued_scans.pop_front();
      compare("line_enable", 32'(want.line_enable), 32'(got.line_enable));
      compare("line_level",  32'(want.line_level),  32'(got.line_level));
      compare("buzzer_gate", 32'(want.buzzer_gate), 32'(got.buzzer_gate));
      compare("catch_event", 32'(want.catch_event), 32'(got.catch_event));
      compare("start_event", 32'(want.start_event), 32'(got.start_event));
      compare("tick_count",  32'(want.tick_count),  32'(got.tick_count));
    endfunction
  endclass

  // DUT ports
  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [1:0]            action_i;
  logic                  catch_pressed_i;
  logic                  start_pressed_i;
  logic [FRAME_W-1:0]    frame_bits_i;
  logic [PAT_W-1:0]      pattern_id_i;
  logic [1:0]            take_mask_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [LINES-1:0]      line_enable_o;
  logic [LINES-1:0]      line_level_o;
  logic                  buzzer_gate_o;
  logic                  catch_event_o;
  logic                  start_event_o;
  logic [TICK_W-1:0]     tick_count_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  ring_scoreboard board = new();
  bit                quiet     = 1'b0;  // no idling on either side while set
  bit                hold_go   = 1'b0;  // kick off the long receiver hold-off
  logic              rx_hold   = 1'b0;
  bit                catch_lvl = 1'b0;  // held button levels of the random part
  bit                start_lvl = 1'b0;
  int unsigned       cycles    = 0;

  charlieplex_ring_scan_controller dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .catch_pressed_i (catch_pressed_i),
    .start_pressed_i (start_pressed_i),
    .frame_bits_i    (frame_bits_i),
    .pattern_id_i    (pattern_id_i),
    .take_mask_i     (take_mask_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .line_enable_o   (line_enable_o),
    .line_level_o    (line_level_o),
    .buzzer_gate_o   (buzzer_gate_o),
    .catch_event_o   (catch_event_o),
    .start_event_o   (start_event_o),
    .tick_count_o    (tick_count_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Bound the run; a hang anywhere ends here
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_charlieplex_ring_scan_controller: FAIL");
      $finish;
    end
  end

  // Receiver: check each accepted result beat, then pick the next stall
  always @(posedge clk_i) begin
    if (out_valid_o === 1'b1 && !out_stall_i) begin
      board.check_scan({line_enable_o, line_level_o, buzzer_gate_o,
                        catch_event_o, start_event_o, tick_count_o});
    end
    out_stall_i <= rx_hold || (!quiet && $urandom_range(99) < 10);
  end

  // Long hold-off on the result side; the sender keeps offering beats meanwhile,
  // so the block fills up and has to stall its input
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Random field values at their port widths
  function automatic bit rnd_bit();
    return 1'($urandom);
  endfunction

  function automatic bit [FRAME_W-1:0] rnd_frame();
    return FRAME_W'($urandom);
  endfunction

  function automatic bit [PAT_W-1:0] rnd_pat();
    return PAT_W'($urandom);
  endfunction

  function automatic bit [1:0] rnd_mask();
    return 2'($urandom);
  endfunction

  function automatic bit [MAP_W-1:0] rnd_map();
    return MAP_W'($urandom);
  endfunction

  // Offer one item beat, optionally after a short gap, and hold it until taken
  task automatic send_beat(input action_e act, input bit catch_b, input bit start_b,
                           input bit [FRAME_W-1:0] frame, input bit [PAT_W-1:0] pat,
                           input bit [1:0] mask);
    int unsigned gap;
    gap = (!quiet && $urandom_range(99) < 10) ? $urandom_range(1, 5) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    action_i        <= act;
    catch_pressed_i <= catch_b;
    start_pressed_i <= start_b;
    frame_bits_i    <= frame;
    pattern_id_i    <= pat;
    take_mask_i     <= mask;
    do @(posedge clk_i); while (in_stall_o);
    board.note_beat(act, catch_b, start_b, frame, pat, mask);
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.queued_scans.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle until pready
  task automatic write_reg(input cfg_reg_e idx, input bit [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_reg(idx, value);
  endtask

  // Upper data bits carry noise; the block keeps only the register width
  task automatic configure(input bit [MAP_W-1:0] anodes, input bit [MAP_W-1:0] cathodes,
                           input bit [HOLD_W-1:0] release_ms);
    write_reg(REG_ANODE_MAP,    {8'($urandom), anodes});
    write_reg(REG_CATHODE_MAP,  {8'($urandom), cathodes});
    write_reg(REG_RELEASE_TIME, {26'($urandom), release_ms});
  endtask

  // Mostly ticks with held, slowly toggling button levels so the debounce
  // reaches re-arm; pattern starts are rare enough for patterns to run out
  task automatic run_random(input int unsigned beats, input int unsigned pat_pct);
    int unsigned pick;
    bit [PAT_W-1:0] pat;
    repeat (beats) begin
      pick = $urandom_range(99);
      pat  = ($urandom_range(9) == 0) ? PAT_W'($urandom_range(5, 7))
                                      : PAT_W'($urandom_range(0, 4));
      if (pick < pat_pct) begin
        send_beat(ACT_START_PATTERN, rnd_bit(), rnd_bit(), rnd_frame(), pat, rnd_mask());
      end else if (pick < pat_pct + 8) begin
        send_beat(ACT_SET_FRAME, rnd_bit(), rnd_bit(), rnd_frame(), rnd_pat(), rnd_mask());
      end else if (pick < pat_pct + 20) begin
        send_beat(ACT_TAKE_EVENTS, rnd_bit(), rnd_bit(), rnd_frame(), rnd_pat(), rnd_mask());
      end else begin
        if ($urandom_range(5) == 0) catch_lvl = ~catch_lvl;
        if ($urandom_range(5) == 0) start_lvl = ~start_lvl;
        send_beat(ACT_TICK, catch_lvl, start_lvl, rnd_frame(), rnd_pat(), rnd_mask());
      end
    end
    settle();
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    action_i        = ACT_TICK;
    catch_pressed_i = 1'b0;
    start_pressed_i = 1'b0;
    frame_bits_i    = '0;
    pattern_id_i    = '0;
    take_mask_i     = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every anode on line 0, every cathode on line 3, shortest release
    configure(24'h000000, 24'hFFFFFF, 6'd2);
    // blank row, start press
    send_beat(ACT_TICK, 1'b0, 1'b1, rnd_frame(), rnd_pat(), rnd_mask());
    send_beat(ACT_SET_FRAME, 1'b0, 1'b0, 12'hFFF, rnd_pat(), rnd_mask());
    // catch press
    send_beat(ACT_TICK, 1'b1, 1'b0, rnd_frame(), rnd_pat(), rnd_mask());
    // start still held
    send_beat(ACT_TICK, 1'b1, 1'b1, rnd_frame(), rnd_pat(), rnd_mask());
    // row 0 lights
    send_beat(ACT_TICK, 1'b1, 1'b1, rnd_frame(), rnd_pat(), rnd_mask());
    // nothing taken, then each take mask in turn
    send_beat(ACT_TAKE_EVENTS, 1'b0, 1'b0, rnd_frame(), rnd_pat(), 2'b00);
    send_beat(ACT_TAKE_EVENTS, 1'b0, 1'b0, rnd_frame(), rnd_pat(), 2'b01);
    send_beat(ACT_TAKE_EVENTS, 1'b0, 1'b0, rnd_frame(), rnd_pat(), 2'b10);
    send_beat(ACT_TAKE_EVENTS, 1'b0, 1'b0, rnd_frame(), rnd_pat(), 2'b11);
    // re-arm at once
    send_beat(ACT_TICK, 1'b0, 1'b0, rnd_frame(), rnd_pat(), rnd_mask());
    send_beat(ACT_TICK, 1'b0, 1'b0, rnd_frame(), rnd_pat(), rnd_mask());
    // press again
    send_beat(ACT_TICK, 1'b1, 1'b1, rnd_frame(), rnd_pat(), rnd_mask());
    // unknown patterns, ignored, then the known ones
    send_beat(ACT_START_PATTERN, 1'b0, 1'b0, rnd_frame(), 3'd7, rnd_mask());
    send_beat(ACT_START_PATTERN, 1'b0, 1'b0, rnd_frame(), 3'd5, rnd_mask());
    send_beat(ACT_START_PATTERN, 1'b0, 1'b0, rnd_frame(), PAT_CHIRP, rnd_mask());
    send_beat(ACT_TICK, 1'b0, 1'b0, rnd_frame(), rnd_pat(), rnd_mask());
    send_beat(ACT_START_PATTERN, 1'b0, 1'b0, rnd_frame(), PAT_WIN, rnd_mask());
    send_beat(ACT_START_PATTERN, 1'b0, 1'b0, rnd_frame(), PAT_NEAR, rnd_mask());
    send_beat(ACT_START_PATTERN, 1'b0, 1'b0, rnd_frame(), PAT_MISS, rnd_mask());
    send_beat(ACT_START_PATTERN, 1'b0, 1'b0, rnd_frame(), PAT_START, rnd_mask());
    send_beat(ACT_TAKE_EVENTS, 1'b0, 1'b0, rnd_frame(), rnd_pat(), 2'b11);
    settle();

    // Directed: anode equal to cathode on every position, long release
    configure(24'hE4E4E4, 24'hE4E4E4, 6'd62);
    send_beat(ACT_SET_FRAME, 1'b0, 1'b0, 12'h800, rnd_pat(), rnd_mask());
    repeat (3) send_beat(ACT_TICK, 1'b0, 1'b0, rnd_frame(), rnd_pat(), rnd_mask());
    send_beat(ACT_SET_FRAME, 1'b0, 1'b0, 12'h001, rnd_pat(), rnd_mask());
    repeat (2) send_beat(ACT_TICK, 1'b0, 1'b0, rnd_frame(), rnd_pat(), rnd_mask());
    settle();

    // Random: a stretch with no idling at all
    quiet = 1'b1;
    configure(rnd_map(), rnd_map(), RELEASE_RESET_MS);
    run_random(80, 8);
    quiet = 1'b0;

    // Random: long release, rare pattern starts, receiver hold-off
    configure(rnd_map(), rnd_map(), 6'd62);
    hold_go = 1'b1;
    run_random(200, 1);

    // Random: maps at the opposite extreme, shortest release
    configure(24'hFFFFFF, 24'h000000, 6'd2);
    run_random(60, 4);

    configure(rnd_map(), rnd_map(), HOLD_W'($urandom_range(2, 62)));
    run_random(80, 4);

    if (board.mismatches == 0 && board.queued_scans.size() == 0) begin
      $display("tb_charlieplex_ring_scan_controller: PASS");
    end else begin
      $display("tb_charlieplex_ring_scan_controller: FAIL");
    end
    $finish;
  end

endmodule
